// ----- design/twlru_pkg.sv -----
`default_nettype none

package twlru_pkg;

  // Geometry of the cache and of the reference address.
  localparam int SET_COUNT    = 64;
  localparam int OFFSET_BITS  = 5;
  localparam int ADDRESS_BITS = 32;

  localparam int SET_BITS   = $clog2(SET_COUNT);
  localparam int BLOCK_BITS = ADDRESS_BITS - OFFSET_BITS;
  localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;

  // Width of the saturating hit counter.
  localparam int HIT_BITS = 32;
  localparam logic [HIT_BITS-1:0] HIT_MAX = {HIT_BITS{1'b1}};

  // Way codes.
  localparam logic WAY0 = 1'b0;
  localparam logic WAY1 = 1'b1;

  // A line fill into the tag store.
  typedef struct packed {
    logic                en;
    logic [SET_BITS-1:0] idx;
    logic                way;
    logic [TAG_BITS-1:0] tag;
  } fill_t;

endpackage

`default_nettype wire

// ----- design/twlru_tag_store.sv -----
`default_nettype none

module twlru_tag_store (
  input  wire                             clk,
  input  wire  [twlru_pkg::SET_BITS-1:0]  rd_idx,
  input  wire  twlru_pkg::fill_t          fill,
  output logic [twlru_pkg::TAG_BITS-1:0]  tag0,
  output logic [twlru_pkg::TAG_BITS-1:0]  tag1
);
  import twlru_pkg::*;

  logic [TAG_BITS-1:0] mem0 [SET_COUNT];
  logic [TAG_BITS-1:0] mem1 [SET_COUNT];

  logic [TAG_BITS-1:0] rd0;
  logic [TAG_BITS-1:0] rd1;
  logic                byp0;
  logic                byp1;
  logic [TAG_BITS-1:0] byp_tag;

  always_ff @(posedge clk) begin
    if (fill.en && fill.way == WAY0) begin
      mem0[fill.idx] <= fill.tag;
    end
    rd0 <= mem0[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (fill.en && fill.way == WAY1) begin
      mem1[fill.idx] <= fill.tag;
    end
    rd1 <= mem1[rd_idx];
  end

  // A fill landing on the set being read in the same cycle is not seen
  // by the read port, so the written tag is forwarded.
  always_ff @(posedge clk) begin
    byp0    <= fill.en && (fill.way == WAY0) && (fill.idx == rd_idx);
    byp1    <= fill.en && (fill.way == WAY1) && (fill.idx == rd_idx);
    byp_tag <= fill.tag;
  end

  assign tag0 = byp0 ? byp_tag : rd0;
  assign tag1 = byp1 ? byp_tag : rd1;

endmodule

`default_nettype wire

// ----- design/two_way_lru_cache_lookup_core.sv -----
`default_nettype none

// Two-way set-associative cache lookup with LRU replacement. A request
// carries one byte address and is taken at every rising edge where start
// is high; busy is always low, so one request can be issued in every
// cycle. The result of each request is loaded into the result register
// at the first rising edge after the request was taken. It then stays on
// the result ports for exactly one cycle, marked by done, and is captured
// while done is high. The receiver has no way to
// hold it off and must capture it then.
// The lookup is pipelined around the tag RAM, whose read data is
// registered: the edge that takes the request also reads the tags of the
// selected set, and the cycle after it compares them, updates the valid,
// LRU and counter state and loads the result register. Results come out
// in request order. Each
// result gives the address split into byte offset, block number, set
// index and tag, the way that hit or was filled, a miss flag, a
// replacement flag with the evicted tag (zero when nothing was evicted)
// and the running hit count including this request, which saturates at
// its maximum. After reset all lines are invalid and the hit count is
// zero; no clearing pass is needed.
module two_way_lru_cache_lookup_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [twlru_pkg::ADDRESS_BITS-1:0] address,
  output logic                               done,
  output logic [twlru_pkg::OFFSET_BITS-1:0]  byte_offset,
  output logic [twlru_pkg::BLOCK_BITS-1:0]   block_number,
  output logic [twlru_pkg::SET_BITS-1:0]     set_index,
  output logic                               way,
  output logic [twlru_pkg::TAG_BITS-1:0]     tag,
  output logic                               miss,
  output logic                               replaced,
  output logic [twlru_pkg::TAG_BITS-1:0]     evicted_tag,
  output logic [twlru_pkg::HIT_BITS-1:0]     hit_count
);
  import twlru_pkg::*;

  // The lookup never stalls.
  assign busy = 1'b0;

  // Lookup stage: the request being compared against the tags.
  logic                    s1_valid;
  logic [ADDRESS_BITS-1:0] s1_addr;

  // Per-set state kept in flip-flops so that reset clears it at once.
  logic [SET_COUNT-1:0] valid0;
  logic [SET_COUNT-1:0] valid1;
  logic [SET_COUNT-1:0] victim_is_way1;
  logic [HIT_BITS-1:0]  hits_seen;
  logic [HIT_BITS-1:0]  hits_seen_next;

  logic [OFFSET_BITS-1:0] s1_offset;
  logic [BLOCK_BITS-1:0]  s1_block;
  logic [SET_BITS-1:0]    s1_set;
  logic [TAG_BITS-1:0]    s1_tag;
  logic [TAG_BITS-1:0]    tag0;
  logic [TAG_BITS-1:0]    tag1;
  logic                   v0;
  logic                   v1;
  logic                   hit0;
  logic                   hit1;
  logic                   s1_miss;
  logic                   s1_full;
  logic                   s1_way;
  logic                   s1_replaced;
  logic [TAG_BITS-1:0]    s1_evicted;
  fill_t                  fill;

  // The tag RAM is read with the set of the incoming address so that the
  // tags are ready when the request reaches the lookup stage.
  twlru_tag_store u_tags (
    .clk    (clk),
    .rd_idx (address[OFFSET_BITS +: SET_BITS]),
    .fill   (fill),
    .tag0   (tag0),
    .tag1   (tag1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_addr <= address;
  end

  assign s1_offset = s1_addr[OFFSET_BITS-1:0];
  assign s1_block  = s1_addr[ADDRESS_BITS-1:OFFSET_BITS];
  assign s1_set    = s1_block[SET_BITS-1:0];
  assign s1_tag    = s1_block[BLOCK_BITS-1:SET_BITS];

  assign v0 = valid0[s1_set];
  assign v1 = valid1[s1_set];

  // Only valid ways can hit, and way 0 wins if both were to match.
  assign hit0    = v0 && (tag0 == s1_tag);
  assign hit1    = v1 && (tag1 == s1_tag) && !hit0;
  assign s1_miss = !hit0 && !hit1;
  assign s1_full = v0 && v1;

  // On a miss into a full set the LRU way is replaced; otherwise the
  // invalid way is filled, way 0 first when both are empty.
  always_comb begin
    if (hit0) begin
      s1_way = WAY0;
    end else if (hit1) begin
      s1_way = WAY1;
    end else if (s1_full) begin
      s1_way = victim_is_way1[s1_set];
    end else begin
      s1_way = v0;
    end
  end

  assign s1_replaced = s1_miss && s1_full;
  assign s1_evicted  = !s1_replaced ? '0 : (s1_way == WAY1) ? tag1 : tag0;

  assign fill.en  = s1_valid && s1_miss;
  assign fill.idx = s1_set;
  assign fill.way = s1_way;
  assign fill.tag = s1_tag;

  always_comb begin
    hits_seen_next = hits_seen;
    if (s1_valid && !s1_miss && hits_seen != HIT_MAX) begin
      hits_seen_next = hits_seen + 1'b1;
    end
  end

  // State update. Whichever way was just used, the other one becomes the
  // least recently used.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0         <= '0;
      valid1         <= '0;
      victim_is_way1 <= '0;
      hits_seen      <= '0;
    end else begin
      hits_seen <= hits_seen_next;
      if (s1_valid) begin
        victim_is_way1[s1_set] <= ~s1_way;
        if (s1_miss) begin
          if (s1_way == WAY1) begin
            valid1[s1_set] <= 1'b1;
          end else begin
            valid0[s1_set] <= 1'b1;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    byte_offset  <= s1_offset;
    block_number <= s1_block;
    set_index    <= s1_set;
    way          <= s1_way;
    tag          <= s1_tag;
    miss         <= s1_miss;
    replaced     <= s1_replaced;
    evicted_tag  <= s1_evicted;
    hit_count    <= hits_seen_next;
  end

endmodule

`default_nettype wire

// ----- sim/cache_lookup_checker.sv -----
`timescale 1ns / 1ps

module cache_lookup_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire                                busy,
  input  wire  [twlru_pkg::ADDRESS_BITS-1:0] address,
  input  wire                                done,
  input  wire  [twlru_pkg::OFFSET_BITS-1:0]  byte_offset,
  input  wire  [twlru_pkg::BLOCK_BITS-1:0]   block_number,
  input  wire  [twlru_pkg::SET_BITS-1:0]     set_index,
  input  wire                                way,
  input  wire  [twlru_pkg::TAG_BITS-1:0]     tag,
  input  wire                                miss,
  input  wire                                replaced,
  input  wire  [twlru_pkg::TAG_BITS-1:0]     evicted_tag,
  input  wire  [twlru_pkg::HIT_BITS-1:0]     hit_count,
  output int                                 mismatches,
  output int                                 pending
);
  import twlru_pkg::*;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [BLOCK_BITS-1:0]  block_number;
    logic [SET_BITS-1:0]    set_index;
    logic                   way;
    logic [TAG_BITS-1:0]    tag;
    logic                   miss;
    logic                   replaced;
    logic [TAG_BITS-1:0]    evicted_tag;
    logic [HIT_BITS-1:0]    hit_count;
  } lookup_result_t;

  lookup_result_t      expected_lookups[$];

  // Shadow copy of the cache directory.
  logic                line_valid0 [SET_COUNT];
  logic                line_valid1 [SET_COUNT];
  logic [TAG_BITS-1:0] line_tag0   [SET_COUNT];
  logic [TAG_BITS-1:0] line_tag1   [SET_COUNT];
  logic                lru_is_way1 [SET_COUNT];
  logic [HIT_BITS-1:0] hits_so_far;

  function automatic void clear_directory();
    for (int i = 0; i < SET_COUNT; i++) begin
      line_valid0[i] = 1'b0;
      line_valid1[i] = 1'b0;
      line_tag0[i]   = '0;
      line_tag1[i]   = '0;
      lru_is_way1[i] = 1'b0;
    end
    hits_so_far = '0;
  endfunction

  // Looks one address up in the shadow directory and updates it.
  function automatic lookup_result_t predict_lookup(input logic [ADDRESS_BITS-1:0] addr);
    lookup_result_t      r;
    logic [SET_BITS-1:0] s;
    logic [TAG_BITS-1:0] t;
    r              = '0;
    r.byte_offset  = addr[OFFSET_BITS-1:0];
    r.block_number = addr[ADDRESS_BITS-1:OFFSET_BITS];
    s              = r.block_number[SET_BITS-1:0];
    t              = r.block_number[BLOCK_BITS-1:SET_BITS];
    r.set_index    = s;
    r.tag          = t;
    if (line_valid0[s] && line_tag0[s] == t) begin
      r.way          = WAY0;
      lru_is_way1[s] = 1'b1;
      if (hits_so_far != HIT_MAX) hits_so_far = hits_so_far + 1'b1;
    end else if (line_valid1[s] && line_tag1[s] == t) begin
      r.way          = WAY1;
      lru_is_way1[s] = 1'b0;
      if (hits_so_far != HIT_MAX) hits_so_far = hits_so_far + 1'b1;
    end else begin
      r.miss = 1'b1;
      if (line_valid0[s] && line_valid1[s]) begin
        r.replaced    = 1'b1;
        r.way         = lru_is_way1[s] ? WAY1 : WAY0;
        r.evicted_tag = (r.way == WAY1) ? line_tag1[s] : line_tag0[s];
      end else begin
        r.way = line_valid0[s] ? WAY1 : WAY0;
      end
      if (r.way == WAY1) begin
        line_tag1[s]   = t;
        line_valid1[s] = 1'b1;
      end else begin
        line_tag0[s]   = t;
        line_valid0[s] = 1'b1;
      end
      lru_is_way1[s] = (r.way == WAY0);
    end
    r.hit_count = hits_so_far;
    return r;
  endfunction

  function automatic int check_field(input string name, input logic [63:0] exp,
                                     input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t e;
    int             bad;
    bad = 0;
    if (rst) begin
      clear_directory();
      expected_lookups.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (start && !busy) expected_lookups.push_back(predict_lookup(address));
      if (done) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no request outstanding");
          bad = 1;
        end else begin
          e = expected_lookups.pop_front();
          bad += check_field("byte_offset", 64'(e.byte_offset), 64'(byte_offset));
          bad += check_field("block_number", 64'(e.block_number), 64'(block_number));
          bad += check_field("set_index", 64'(e.set_index), 64'(set_index));
          bad += check_field("way", 64'(e.way), 64'(way));
          bad += check_field("tag", 64'(e.tag), 64'(tag));
          bad += check_field("miss", 64'(e.miss), 64'(miss));
          bad += check_field("replaced", 64'(e.replaced), 64'(replaced));
          bad += check_field("evicted_tag", 64'(e.evicted_tag), 64'(evicted_tag));
          bad += check_field("hit_count", 64'(e.hit_count), 64'(hit_count));
        end
      end
      mismatches <= mismatches + bad;
      pending    <= expected_lookups.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import twlru_pkg::*;

  // The run is cut short once this many cycles pass with no request taken
  // and no result delivered. This is far beyond the longest gap between
  // requests plus the lookup latency in any correct run.
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_COUNT = 1550;
  localparam int POOL_DEPTH   = 3;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [ADDRESS_BITS-1:0]  address = '0;
  logic                     busy;
  logic                     done;
  logic [OFFSET_BITS-1:0]   byte_offset;
  logic [BLOCK_BITS-1:0]    block_number;
  logic [SET_BITS-1:0]      set_index;
  logic                     way;
  logic [TAG_BITS-1:0]      tag;
  logic                     miss;
  logic                     replaced;
  logic [TAG_BITS-1:0]      evicted_tag;
  logic [HIT_BITS-1:0]      hit_count;
  int                       mismatches;
  int                       pending;
  int                       idle_cycles = 0;

  // A few tags per set, so that random requests keep coming back to lines
  // that are resident and the sets cycle through fills, hits and evictions.
  logic [TAG_BITS-1:0]      tag_pool [SET_COUNT][POOL_DEPTH];
  logic [ADDRESS_BITS-1:0]  directed_addrs[$];
  bit                       burst_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_way_lru_cache_lookup_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .address      (address),
    .done         (done),
    .byte_offset  (byte_offset),
    .block_number (block_number),
    .set_index    (set_index),
    .way          (way),
    .tag          (tag),
    .miss         (miss),
    .replaced     (replaced),
    .evicted_tag  (evicted_tag),
    .hit_count    (hit_count)
  );

  cache_lookup_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .address      (address),
    .done         (done),
    .byte_offset  (byte_offset),
    .block_number (block_number),
    .set_index    (set_index),
    .way          (way),
    .tag          (tag),
    .miss         (miss),
    .replaced     (replaced),
    .evicted_tag  (evicted_tag),
    .hit_count    (hit_count),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Watchdog: any taken request or delivered result counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Gap before a request. In burst mode requests go back to back; otherwise
  // most gaps are short and a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly addresses built from the tag pool, with random byte offsets;
  // the rest are fully random addresses that almost always miss.
  function automatic logic [ADDRESS_BITS-1:0] pick_address();
    int                  r;
    int                  slot;
    logic [SET_BITS-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    s = SET_BITS'($urandom_range(0, SET_COUNT - 1));
    r = $urandom_range(0, 99);
    slot = (r < 40) ? 0 : (r < 80) ? 1 : 2;
    return {tag_pool[s][slot], s, OFFSET_BITS'($urandom)};
  endfunction

  // Drives one request at the falling edge and holds it until it is taken.
  // Start is left high so that a following request can go back to back.
  task automatic send_request(input logic [ADDRESS_BITS-1:0] addr, input int gap);
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start   <= 1'b1;
    address <= addr;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int k = 0; k < POOL_DEPTH; k++) tag_pool[s][k] = TAG_BITS'($urandom);
    end
    // The lowest and highest tags live in the first and last sets.
    tag_pool[0][0]             = '0;
    tag_pool[SET_COUNT-1][0]   = '1;

    // Directed part. In set 0: fill way 0, hit it at the top byte of the
    // line, fill way 1, hit way 1, then misses into a full set that
    // evict the LRU way each time. Fills, hits and LRU evictions also run in
    // set 63 with the largest tags, so the evicted tag reaches its maximum.
    // Then some alternating bit patterns.
    directed_addrs = '{
      32'h0000_0000, 32'h0000_001F, 32'h0000_0800, 32'h0000_0800,
      32'h0000_1000, 32'h0000_0000, 32'h0000_0800,
      32'hFFFF_FFFF, 32'hFFFF_FFE0, 32'hFFFF_F7FF, 32'h0000_07E0,
      32'hFFFF_FFFF, 32'h0000_07FF, 32'hFFFF_F7E0,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h8000_0000, 32'h0000_0001, 32'h8000_0001
    };

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_addrs[i]) send_request(directed_addrs[i], (i % 3 == 2) ? 1 : 0);

    burst_mode = 1'b0;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // Switch between back-to-back stretches and stretches with random gaps.
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_request(pick_address(), pick_gap());
    end
    @(negedge clk) start <= 1'b0;

    // Drain; the watchdog catches a result that never shows up. The bench then
    // runs on to catch any result that comes without a request.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
